// ----- hw/rtl/rdtb_pkg.sv -----
// shared constants and types of the reciprocal depth test buffer
`default_nettype none

package rdtb_pkg;

	// default screen size in pixels
	localparam int SCREEN_W_DEF = 512;
	localparam int SCREEN_H_DEF = 512;

	// uq16.16 formats
	localparam int          DEPTH_BITS = 32;
	localparam logic [31:0] RECIP_MAX  = 32'hFFFF_FFFF;
	localparam logic [31:0] ONE_UQ16   = 32'h0001_0000;

	// 2^48 / z leaves 2^16 as remainder once the upper dividend bits are consumed
	localparam logic [31:0] DIV_REM_INIT = 32'h0001_0000;
	localparam int          DIV_STEPS    = 32;

	// mode codes of an input word
	localparam logic MODE_TEST  = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	// sequencer states, one-hot
	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_READ  = 5'b01000,
		ST_TEST  = 5'b10000
	} state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/reciprocal_depth_test_buffer.sv -----
// depth test unit over a per-pixel memory of uq16.16 reciprocal depth
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | start / busy       | mode, pixel_x, pixel_y, depth_z
//  result   | done (one cycle)   | pass, was_clear
//
// a fragment word passes through accept, the bit-serial divider forming
// floor(2^48/z), a read of the depth memory and a compare with write back
// before its done strobe. a depth at or below 1.0 saturates and skips the
// divider. an off-screen fragment is answered in the cycle after accept and
// leaves busy low.
// a clear word sweeps the memory one entry a cycle, all SCREEN_W*SCREEN_H
// entries, then strobes done. after reset the same sweep runs with busy
// high and no result. the receiver cannot stall: each result is shown for
// exactly one cycle.
`default_nettype none

module reciprocal_depth_test_buffer #(
	parameter int SCREEN_W = rdtb_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H = rdtb_pkg::SCREEN_H_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input word
	input  wire logic        start,
	output logic             busy,
	input  wire logic        mode,
	input  wire logic [8:0]  pixel_x,
	input  wire logic [8:0]  pixel_y,
	input  wire logic [31:0] depth_z,
	// result word
	output logic             done,
	output logic             pass,
	output logic             was_clear
);

	localparam int DEPTH = SCREEN_W * SCREEN_H;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(rdtb_pkg::DIV_STEPS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] LAST_STEP = CW'(rdtb_pkg::DIV_STEPS - 1);

	// depth memory, one uq16.16 reciprocal per pixel, no reset of its own
	logic [rdtb_pkg::DEPTH_BITS-1:0] mem [DEPTH];

	rdtb_pkg::state_t state_q;

	logic [AW-1:0] clr_addr_q;   // sweep pointer of the clearing pass
	logic          clr_reply_q;  // sweep answers a clear word, not reset
	logic [AW-1:0] idx_q;        // memory address of the fragment
	logic [31:0]   z_q;          // divisor
	logic [31:0]   rem_q;        // partial remainder, below z while dividing
	logic [31:0]   quo_q;        // quotient, then the reciprocal to store
	logic [CW-1:0] div_cnt_q;
	logic [31:0]   rd_data_q;    // registered memory read

	logic          done_q;
	logic          pass_q;
	logic          was_clear_q;

	logic          accept;
	logic          on_screen;
	logic          saturate;
	logic [AW-1:0] pix_idx;
	logic [32:0]   rem_dbl;
	logic          rem_ge;
	logic          test_pass;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [31:0]   mem_wd;

	assign accept    = start && !busy;
	assign on_screen = (13'(pixel_x) < 13'(SCREEN_W)) && (13'(pixel_y) < 13'(SCREEN_H));
	// z at or below 1.0 gives a quotient of 2^32 or more
	assign saturate  = depth_z <= rdtb_pkg::ONE_UQ16;
	// row-major pixel index, bounded by the on-screen check
	assign pix_idx   = AW'(32'(pixel_y) * 32'(SCREEN_W) + 32'(pixel_x));

	// one restoring division step: shift, compare, subtract
	assign rem_dbl   = {rem_q, 1'b0};
	assign rem_ge    = rem_dbl >= {1'b0, z_q};

	// fail only when the stored reciprocal is strictly greater
	assign test_pass = !(rd_data_q > quo_q);

	// single write port: zeros while sweeping, the reciprocal on a pass
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = quo_q;
		case (state_q)
			rdtb_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_addr_q;
				mem_wd = '0;
			end
			rdtb_pkg::ST_TEST: begin
				mem_we = test_pass;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// memory write and registered read, one word an item so no overlap
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (state_q == rdtb_pkg::ST_READ) begin
			rd_data_q <= mem[idx_q];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rdtb_pkg::ST_CLEAR;
			clr_addr_q  <= '0;
			clr_reply_q <= 1'b0;
			div_cnt_q   <= '0;
			done_q      <= 1'b0;
			pass_q      <= 1'b0;
			was_clear_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				rdtb_pkg::ST_CLEAR: begin
					if (clr_addr_q == LAST_ADDR) begin
						clr_addr_q <= '0;
						state_q    <= rdtb_pkg::ST_IDLE;
						// a clear word is answered, the reset sweep is not
						if (clr_reply_q) begin
							done_q      <= 1'b1;
							pass_q      <= 1'b1;
							was_clear_q <= 1'b1;
						end
					end else begin
						clr_addr_q <= clr_addr_q + 1'b1;
					end
				end
				rdtb_pkg::ST_IDLE: begin
					if (accept) begin
						if (mode == rdtb_pkg::MODE_CLEAR) begin
							clr_reply_q <= 1'b1;
							state_q     <= rdtb_pkg::ST_CLEAR;
						end else if (!on_screen) begin
							// off-screen fragment: answered at once, memory untouched
							done_q      <= 1'b1;
							pass_q      <= 1'b0;
							was_clear_q <= 1'b0;
						end else if (saturate) begin
							state_q <= rdtb_pkg::ST_READ;
						end else begin
							div_cnt_q <= '0;
							state_q   <= rdtb_pkg::ST_DIV;
						end
					end
				end
				rdtb_pkg::ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == LAST_STEP) begin
						state_q <= rdtb_pkg::ST_READ;
					end
				end
				rdtb_pkg::ST_READ: begin
					state_q <= rdtb_pkg::ST_TEST;
				end
				rdtb_pkg::ST_TEST: begin
					done_q      <= 1'b1;
					pass_q      <= test_pass;
					was_clear_q <= 1'b0;
					state_q     <= rdtb_pkg::ST_IDLE;
				end
				default: begin
					state_q <= rdtb_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// fragment payload and divider datapath
	always_ff @(posedge clk) begin
		if (state_q == rdtb_pkg::ST_IDLE && accept) begin
			idx_q <= pix_idx;
			z_q   <= depth_z;
			rem_q <= rdtb_pkg::DIV_REM_INIT;
			quo_q <= saturate ? rdtb_pkg::RECIP_MAX : '0;
		end else if (state_q == rdtb_pkg::ST_DIV) begin
			rem_q <= rem_ge ? 32'(rem_dbl - {1'b0, z_q}) : rem_dbl[31:0];
			quo_q <= {quo_q[30:0], rem_ge};
		end
	end

	assign busy      = state_q != rdtb_pkg::ST_IDLE;
	assign done      = done_q;
	assign pass      = pass_q;
	assign was_clear = was_clear_q;

	// a clear answer always passes
	a_clear_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && was_clear_q) |-> pass_q)
		else $error("clear answered without pass");

	// the compare stage always produces exactly one answer and frees the block
	a_test_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rdtb_pkg::ST_TEST) |=> (done_q && !was_clear_q && !busy))
		else $error("compare stage gave no answer");

	// off-screen fragments fail in the next cycle
	a_offscreen: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == rdtb_pkg::MODE_TEST && !on_screen) |=> (done_q && !pass_q))
		else $error("off-screen fragment not rejected");

	// the divider leaves after its last step straight into the memory read
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rdtb_pkg::ST_DIV && div_cnt_q == LAST_STEP)
		|=> (state_q == rdtb_pkg::ST_READ))
		else $error("divider step count off");

	// the sweep pointer rests at zero between clears
	a_sweep_rest: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != rdtb_pkg::ST_CLEAR) |-> (clr_addr_q == '0))
		else $error("sweep pointer not parked");

endmodule

`default_nettype wire

// ----- tb/tb_reciprocal_depth_test_buffer.sv -----
// self-checking testbench of the reciprocal depth test buffer: depth predictor, driver and monitor
`default_nettype none

module tb_reciprocal_depth_test_buffer;

	import rdtb_pkg::*;

	// one input word and one result word
	typedef struct {
		logic        mode;
		logic [8:0]  x;
		logic [8:0]  y;
		logic [31:0] z;
	} frag_word_t;

	typedef struct {
		logic pass;
		logic was_clear;
	} depth_result_t;

	// no idle bursts once this few words are left
	localparam int QUIET_TAIL   = 150;
	localparam int RANDOM_WORDS = 2000;
	localparam int HOT_PIXELS   = 16;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        mode = MODE_TEST;
	logic [8:0]  pixel_x = '0;
	logic [8:0]  pixel_y = '0;
	logic [31:0] depth_z = '0;
	logic        done;
	logic        pass;
	logic        was_clear;

	// words waiting to be driven, and results waiting to come back
	frag_word_t    word_q[$];
	depth_result_t result_q[$];

	// own copy of the depth memory; an absent entry reads as zero
	logic [31:0] recip_mem [int unsigned];

	frag_word_t cur_word;
	int         idle_left = 0;
	int         n_sent = 0;
	int         n_err = 0;
	int         n_pass = 0;
	int         n_fail = 0;
	int         n_clear = 0;

	reciprocal_depth_test_buffer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.depth_z   (depth_z),
		.done      (done),
		.pass      (pass),
		.was_clear (was_clear)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// uq16.16 reciprocal floor(2^48/z), saturated; zero depth saturates too
	function automatic logic [31:0] depth_recip(logic [31:0] z);
		logic [63:0] q;
		if (z == '0)
			return RECIP_MAX;
		q = 64'h0001_0000_0000_0000 / {32'd0, z};
		if (q > {32'd0, RECIP_MAX})
			return RECIP_MAX;
		return q[31:0];
	endfunction

	// apply one accepted word to the depth memory, queue the result it causes
	task automatic predict_depth_test(frag_word_t w);
		depth_result_t r;
		logic [31:0]   recip;
		logic [31:0]   stored;
		int unsigned   idx;
		if (w.mode == MODE_CLEAR) begin
			recip_mem.delete();
			r.pass = 1'b1;
			r.was_clear = 1'b1;
			n_clear++;
		end else begin
			r.was_clear = 1'b0;
			if (w.x >= SCREEN_W_DEF || w.y >= SCREEN_H_DEF) begin
				// off-screen: memory left alone
				r.pass = 1'b0;
			end else begin
				idx = w.y * SCREEN_W_DEF + w.x;
				recip = depth_recip(w.z);
				stored = recip_mem.exists(idx) ? recip_mem[idx] : '0;
				// strictly greater stored value means farther fragment loses
				if (stored > recip) begin
					r.pass = 1'b0;
					n_fail++;
				end else begin
					recip_mem[idx] = recip;
					r.pass = 1'b1;
					n_pass++;
				end
			end
		end
		result_q.push_back(r);
	endtask

	task automatic push_word(logic m, logic [8:0] x, logic [8:0] y, logic [31:0] z);
		frag_word_t w;
		w.mode = m;
		w.x = x;
		w.y = y;
		w.z = z;
		word_q.push_back(w);
	endtask

	// driver: a word is taken at an edge where start is high and busy is low;
	// a word not yet taken keeps start high, so start gets one update per edge
	always @(posedge clk or negedge arst_n) begin : drive_proc
		logic go;
		if (!arst_n) begin
			start <= 1'b0;
			mode <= MODE_TEST;
			pixel_x <= '0;
			pixel_y <= '0;
			depth_z <= '0;
			idle_left <= 0;
		end else begin
			go = start;
			if (start && !busy) begin
				predict_depth_test(cur_word);
				go = 1'b0;
			end
			if (!go) begin
				if (idle_left != 0) begin
					idle_left <= idle_left - 1;
				end else if (word_q.size() != 0) begin
					// idle bursts only in every other stretch of 200 words, none in the tail
					if (word_q.size() > QUIET_TAIL && ((n_sent / 200) % 2) == 1
							&& $urandom_range(0, 3) == 0) begin
						idle_left <= $urandom_range(0, 17);
					end else begin
						cur_word = word_q.pop_front();
						mode <= cur_word.mode;
						pixel_x <= cur_word.x;
						pixel_y <= cur_word.y;
						depth_z <= cur_word.z;
						n_sent++;
						go = 1'b1;
					end
				end
			end
			start <= go;
		end
	end

	// monitor: every done strobe is one result word, checked against the oldest expected one
	always @(posedge clk) begin : check_proc
		depth_result_t exp_r;
		if (arst_n && done !== 1'b0) begin
			if (result_q.size() == 0) begin
				$error("result word with none expected: pass=%0b was_clear=%0b",
					pass, was_clear);
				n_err++;
			end else begin
				exp_r = result_q.pop_front();
				if (pass !== exp_r.pass) begin
					$error("pass: expected %0b, got %0b", exp_r.pass, pass);
					n_err++;
				end
				if (was_clear !== exp_r.was_clear) begin
					$error("was_clear: expected %0b, got %0b", exp_r.was_clear, was_clear);
					n_err++;
				end
			end
		end
	end

	// hard stop well past the slowest correct run: reset sweep, two clear sweeps,
	// and every word through the divider plus the longest idle burst
	initial begin
		#20000000;
		$display("reciprocal_depth_test_buffer: mismatch");
		$finish;
	end

	initial begin : stim_proc
		logic [8:0]  hot_x [HOT_PIXELS];
		logic [8:0]  hot_y [HOT_PIXELS];
		logic [31:0] hot_z [HOT_PIXELS];
		logic [8:0]  x;
		logic [8:0]  y;
		logic [31:0] z;
		int          k;
		int          pick;
		bit          hot;

		// directed words: saturation at zero and at one, equal values, corners, clear
		push_word(MODE_TEST, 9'd0, 9'd0, 32'h0000_0000);
		push_word(MODE_TEST, 9'd0, 9'd0, ONE_UQ16);               // equal saturated value
		push_word(MODE_TEST, 9'd0, 9'd0, 32'h0002_0000);          // farther, loses
		push_word(MODE_TEST, 9'd511, 9'd511, 32'hFFFF_FFFF);      // smallest reciprocal
		push_word(MODE_TEST, 9'd511, 9'd511, 32'hFFFF_FFFF);      // equal, rewrites
		push_word(MODE_TEST, 9'd511, 9'd511, ONE_UQ16 + 32'd1);   // just above one
		push_word(MODE_TEST, 9'd511, 9'd0, 32'h0000_0001);        // tiny depth saturates
		push_word(MODE_TEST, 9'd0, 9'd511, 32'h0001_0001);
		push_word(MODE_TEST, 9'h155, 9'h0AA, 32'hAAAA_5555);
		push_word(MODE_TEST, 9'h0AA, 9'h155, 32'h5555_AAAA);
		push_word(MODE_TEST, 9'd256, 9'd255, 32'h0001_8000);
		push_word(MODE_TEST, 9'd256, 9'd255, 32'h0001_8001);      // slightly farther, loses
		push_word(MODE_TEST, 9'd256, 9'd255, 32'h0001_7FFF);      // slightly nearer, wins
		push_word(MODE_CLEAR, 9'h1FF, 9'h1FF, 32'hFFFF_FFFF);     // payload ignored on clear
		push_word(MODE_TEST, 9'd0, 9'd0, 32'hFFFF_FFFF);          // passes again after clear
		push_word(MODE_TEST, 9'd511, 9'd511, 32'h8000_0000);
		push_word(MODE_TEST, 9'd511, 9'd511, 32'hFFFF_FFFF);      // farther, loses
		push_word(MODE_TEST, 9'd256, 9'd255, 32'h0001_8001);

		// a few hot pixels take most fragments so depth comparisons hit stored values
		for (int i = 0; i < HOT_PIXELS; i++) begin
			hot_x[i] = (i == 0) ? 9'd0 : (i == 1) ? 9'd511 : 9'($urandom);
			hot_y[i] = (i == 0) ? 9'd0 : (i == 1) ? 9'd511 : 9'($urandom);
			hot_z[i] = $urandom;
		end

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			// one clear in the middle; a clear sweep is far too slow for more
			if (i == RANDOM_WORDS / 2) begin
				push_word(MODE_CLEAR, 9'($urandom), 9'($urandom), $urandom);
				continue;
			end
			hot = ($urandom_range(0, 99) < 70);
			k = $urandom_range(0, HOT_PIXELS - 1);
			x = hot ? hot_x[k] : 9'($urandom);
			y = hot ? hot_y[k] : 9'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 25)
				z = $urandom;
			else if (pick < 45)
				z = $urandom_range(0, ONE_UQ16);
			else if (pick < 70)
				z = $urandom >> $urandom_range(0, 31);
			else if (pick < 85 && hot)
				z = hot_z[k] + $urandom_range(0, 2) - 1;  // same or neighboring depth
			else begin
				case ($urandom_range(0, 4))
					0: z = '0;
					1: z = ONE_UQ16;
					2: z = ONE_UQ16 + 32'd1;
					3: z = 32'hFFFF_FFFF;
					default: z = 32'h0001_8000;
				endcase
			end
			if (hot)
				hot_z[k] = z;
			push_word(MODE_TEST, x, y, z);
		end

		// reset once, the block then sweeps its memory with busy high
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (word_q.size() == 0 && !start && result_q.size() == 0);
		// room for a stray strobe after the last result
		repeat (40) @(posedge clk);

		$display("covered %0d words: %0d fragments passed, %0d failed, %0d clears",
			n_sent, n_pass, n_fail, n_clear);
		if (n_err == 0)
			$display("reciprocal_depth_test_buffer: match");
		else
			$display("reciprocal_depth_test_buffer: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
